@@ src/ffca_pkg.sv @@
// Package: shared types and constants of the first-fit coalescing allocator.
`default_nettype none
package ffca_pkg;

	localparam int HEAP_BYTES   = 4096;
	localparam int HEADER_BYTES = 16;
	localparam int ADDR_W       = $clog2(HEAP_BYTES);
	localparam int OFF_W        = ADDR_W + 1;

	localparam logic [OFF_W-1:0] HEAP_END = OFF_W'(HEAP_BYTES);
	localparam logic [OFF_W-1:0] HDR_LEN  = OFF_W'(HEADER_BYTES);

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_FIT   = 2'd1,
		ST_BAD_FREE = 2'd2
	} status_t;

	typedef enum logic {
		MODE_ALLOC = 1'b0,
		MODE_FREE  = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t             mode;
		logic [ADDR_W-1:0] request_size;
		logic [ADDR_W-1:0] block_address;
	} request_t;

	typedef struct packed {
		logic [ADDR_W-1:0] payload_address;
		status_t           status;
	} result_t;

	typedef struct packed {
		logic             is_free;
		logic [OFF_W-1:0] size;
		logic [OFF_W-1:0] prev;
	} hdr_t;

	localparam int HDR_W = $bits(hdr_t);

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_A_CHK,
		S_A_NB,
		S_A_NXR,
		S_A_NXD,
		S_F_CHK,
		S_F_PV,
		S_F_NXR,
		S_F_NXD,
		S_F_WS
	} state_t;

endpackage
`default_nettype wire

@@ src/ffca_ram.sv @@
// Generic single-port RAM with registered read.
`default_nettype none
module ffca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule
`default_nettype wire

@@ src/first_fit_coalescing_allocator.sv @@
// Top level: first-fit heap allocator with coalescing over a header memory.
//
// Raise start with a request while busy is low. An allocate request walks the
// block headers from offset 0, one header read per cycle from the single-port
// header memory, then splits a granted block that is large enough and relinks
// its successor. A free request walks the same chain to validate the offset,
// then reads the neighbours and writes the merged header. A free offset below
// one header length is rejected in the accept cycle. The result appears on
// result for one cycle with done high and cannot be held off. After reset the
// block is busy for one cycle while it writes the initial header at offset 0.
`default_nettype none
module first_fit_coalescing_allocator
	import ffca_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire request_t request,
	output logic          busy,
	output logic          done,
	output result_t       result
);

	state_t state_q, state_d;
	logic [OFF_W-1:0] req_q, req_d;
	logic [OFF_W-1:0] t_q, t_d;
	logic [OFF_W-1:0] cur_q, cur_d;
	logic [OFF_W-1:0] nb_q, nb_d;
	logic [OFF_W-1:0] nx_q, nx_d;
	logic [OFF_W-1:0] start_q, start_d;
	logic [OFF_W-1:0] start_prev_q, start_prev_d;
	logic [OFF_W-1:0] end_q, end_d;
	logic             merged_q, merged_d;
	hdr_t             hdr_q, hdr_d;
	logic             done_q, done_d;
	result_t          result_q, result_d;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_addr;
	hdr_t              ram_wdata;
	logic [HDR_W-1:0]  ram_rdata;
	hdr_t              rd;
	logic [OFF_W-1:0]  blk_end;
	logic [OFF_W-1:0]  pay;
	logic [OFF_W-1:0]  nb_sum;
	logic [OFF_W-1:0]  merged_end;

	ffca_ram #(
		.WIDTH(HDR_W),
		.DEPTH(HEAP_BYTES)
	) u_hdr_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	assign rd         = hdr_t'(ram_rdata);
	assign blk_end    = cur_q + HDR_LEN + rd.size;
	assign pay        = cur_q + HDR_LEN;
	assign nb_sum     = cur_q + HDR_LEN + req_q;
	assign merged_end = end_q + HDR_LEN + rd.size;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q        <= req_d;
		t_q          <= t_d;
		cur_q        <= cur_d;
		nb_q         <= nb_d;
		nx_q         <= nx_d;
		start_q      <= start_d;
		start_prev_q <= start_prev_d;
		end_q        <= end_d;
		merged_q     <= merged_d;
		hdr_q        <= hdr_d;
		result_q     <= result_d;
	end

	always_comb begin
		state_d      = state_q;
		req_d        = req_q;
		t_d          = t_q;
		cur_d        = cur_q;
		nb_d         = nb_q;
		nx_d         = nx_q;
		start_d      = start_q;
		start_prev_d = start_prev_q;
		end_d        = end_q;
		merged_d     = merged_q;
		hdr_d        = hdr_q;
		done_d       = 1'b0;
		result_d     = result_q;
		ram_we       = 1'b0;
		ram_addr     = cur_q[ADDR_W-1:0];
		ram_wdata    = hdr_q;
		unique case (state_q)
			S_INIT: begin
				ram_we    = 1'b1;
				ram_addr  = '0;
				ram_wdata = '{is_free: 1'b1, size: HEAP_END - HDR_LEN, prev: '0};
				state_d   = S_IDLE;
			end
			S_IDLE: begin
				ram_addr = '0;
				if (start) begin
					cur_d = '0;
					req_d = {1'b0, request.request_size};
					t_d   = {1'b0, request.block_address} - HDR_LEN;
					if (request.mode == MODE_ALLOC) begin
						state_d = S_A_CHK;
					end else if ({1'b0, request.block_address} < HDR_LEN) begin
						done_d   = 1'b1;
						result_d = '{payload_address: '0, status: ST_BAD_FREE};
					end else begin
						state_d = S_F_CHK;
					end
				end
			end
			S_A_CHK: begin
				if (rd.is_free && rd.size >= req_q + HDR_LEN) begin
					ram_we   = 1'b1;
					result_d = '{payload_address: pay[ADDR_W-1:0], status: ST_OK};
					if (rd.size - req_q > HDR_LEN) begin
						ram_wdata = '{is_free: 1'b0, size: req_q, prev: rd.prev};
						hdr_d     = '{is_free: 1'b1, size: rd.size - req_q - HDR_LEN,
							prev: cur_q};
						nb_d      = nb_sum;
						nx_d      = blk_end;
						state_d   = S_A_NB;
					end else begin
						ram_wdata = '{is_free: 1'b0, size: rd.size, prev: rd.prev};
						done_d    = 1'b1;
						state_d   = S_IDLE;
					end
				end else if (blk_end >= HEAP_END) begin
					done_d   = 1'b1;
					result_d = '{payload_address: '0, status: ST_NO_FIT};
					state_d  = S_IDLE;
				end else begin
					cur_d    = blk_end;
					ram_addr = blk_end[ADDR_W-1:0];
				end
			end
			S_A_NB: begin
				ram_we    = 1'b1;
				ram_addr  = nb_q[ADDR_W-1:0];
				ram_wdata = hdr_q;
				if (nx_q < HEAP_END) begin
					state_d = S_A_NXR;
				end else begin
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_A_NXR: begin
				ram_addr = nx_q[ADDR_W-1:0];
				state_d  = S_A_NXD;
			end
			S_A_NXD: begin
				ram_we    = 1'b1;
				ram_addr  = nx_q[ADDR_W-1:0];
				ram_wdata = '{is_free: rd.is_free, size: rd.size, prev: nb_q};
				done_d    = 1'b1;
				state_d   = S_IDLE;
			end
			S_F_CHK: begin
				if (cur_q == t_q) begin
					if (rd.is_free) begin
						done_d   = 1'b1;
						result_d = '{payload_address: '0, status: ST_BAD_FREE};
						state_d  = S_IDLE;
					end else begin
						hdr_d        = rd;
						end_d        = blk_end;
						start_d      = t_q;
						start_prev_d = rd.prev;
						merged_d     = 1'b0;
						if (t_q != '0) begin
							ram_addr = rd.prev[ADDR_W-1:0];
							state_d  = S_F_PV;
						end else begin
							state_d = S_F_NXR;
						end
					end
				end else if (cur_q > t_q || blk_end >= HEAP_END) begin
					done_d   = 1'b1;
					result_d = '{payload_address: '0, status: ST_BAD_FREE};
					state_d  = S_IDLE;
				end else begin
					cur_d    = blk_end;
					ram_addr = blk_end[ADDR_W-1:0];
				end
			end
			S_F_PV: begin
				if (hdr_q.prev < HEAP_END && rd.is_free) begin
					start_d      = hdr_q.prev;
					start_prev_d = rd.prev;
				end
				state_d = S_F_NXR;
			end
			S_F_NXR: begin
				ram_addr = end_q[ADDR_W-1:0];
				if (end_q < HEAP_END) begin
					state_d = S_F_NXD;
				end else begin
					state_d = S_F_WS;
				end
			end
			S_F_NXD: begin
				if (rd.is_free && !merged_q) begin
					merged_d = 1'b1;
					end_d    = merged_end;
					state_d  = S_F_NXR;
				end else begin
					ram_we    = 1'b1;
					ram_addr  = end_q[ADDR_W-1:0];
					ram_wdata = '{is_free: rd.is_free, size: rd.size, prev: start_q};
					state_d   = S_F_WS;
				end
			end
			S_F_WS: begin
				ram_we    = 1'b1;
				ram_addr  = start_q[ADDR_W-1:0];
				ram_wdata = '{is_free: 1'b1, size: end_q - start_q - HDR_LEN,
					prev: start_prev_q};
				done_d    = 1'b1;
				result_d  = '{payload_address: '0, status: ST_OK};
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

`ifndef ASSERT_OFF
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while a request is still in work");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != ST_OK |-> result.payload_address == '0)
		else $error("failed request returned a nonzero offset");

	a_alloc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && request.mode == MODE_ALLOC |=> busy && !done)
		else $error("allocate request finished without a header read");
`endif

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
// Testbench for the first-fit coalescing allocator: directed and random requests.
`default_nettype none
module tb
	import ffca_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 50;

	logic     clk;
	logic     arst_n;
	logic     start;
	request_t request;
	logic     busy;
	logic     done;
	result_t  result;

	first_fit_coalescing_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.request(request),
		.busy(busy),
		.done(done),
		.result(result)
	);

	bit      blk_free [HEAP_BYTES];
	int      blk_size [HEAP_BYTES];
	int      blk_prev [HEAP_BYTES];
	result_t pending_results[$];
	int      live_blocks[$];
	int      error_count;
	int      stall_cycles;
	int      gap_percent;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int block_end(int off);
		return off + HEADER_BYTES + blk_size[off];
	endfunction

	function automatic void heap_reset();
		foreach (blk_free[i]) begin
			blk_free[i] = 1'b0;
			blk_size[i] = 0;
			blk_prev[i] = 0;
		end
		blk_free[0] = 1'b1;
		blk_size[0] = HEAP_BYTES - HEADER_BYTES;
	endfunction

	function automatic result_t heap_allocate(int req);
		result_t r;
		int cur, steps, nb, nx;
		r.payload_address = '0;
		r.status = ST_NO_FIT;
		cur = 0;
		steps = 0;
		while (cur < HEAP_BYTES && steps < HEAP_BYTES) begin
			if (blk_free[cur] && blk_size[cur] >= req + HEADER_BYTES) begin
				if (blk_size[cur] - req > HEADER_BYTES) begin
					nb = cur + HEADER_BYTES + req;
					blk_free[nb] = 1'b1;
					blk_size[nb] = blk_size[cur] - req - HEADER_BYTES;
					blk_prev[nb] = cur;
					nx = block_end(nb);
					if (nx < HEAP_BYTES)
						blk_prev[nx] = nb;
					blk_size[cur] = req;
				end
				blk_free[cur] = 1'b0;
				r.payload_address = ADDR_W'(cur + HEADER_BYTES);
				r.status = ST_OK;
				return r;
			end
			cur = block_end(cur);
			steps++;
		end
		return r;
	endfunction

	function automatic result_t heap_release(int p);
		result_t r;
		int t, cur, steps, first, last;
		bit found;
		r.payload_address = '0;
		r.status = ST_BAD_FREE;
		if (p < HEADER_BYTES)
			return r;
		t = p - HEADER_BYTES;
		cur = 0;
		steps = 0;
		found = 1'b0;
		while (cur < HEAP_BYTES && steps < HEAP_BYTES) begin
			if (cur == t) begin
				found = 1'b1;
				break;
			end
			if (cur > t)
				break;
			cur = block_end(cur);
			steps++;
		end
		if (!found || blk_free[t])
			return r;
		first = t;
		last = block_end(t);
		if (t != 0 && blk_prev[t] < HEAP_BYTES && blk_free[blk_prev[t]])
			first = blk_prev[t];
		if (last < HEAP_BYTES && blk_free[last])
			last = block_end(last);
		blk_free[first] = 1'b1;
		blk_size[first] = last - first - HEADER_BYTES;
		if (last < HEAP_BYTES)
			blk_prev[last] = first;
		r.status = ST_OK;
		return r;
	endfunction

	function automatic result_t predict_heap(request_t req);
		if (req.mode == MODE_ALLOC)
			return heap_allocate(int'(req.request_size));
		return heap_release(int'(req.block_address));
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, address", int'(result.payload_address), -1);
			end else begin
				want = pending_results.pop_front();
				if (result.payload_address !== want.payload_address)
					report_mismatch("payload_address", int'(result.payload_address),
						int'(want.payload_address));
				if (result.status !== want.status)
					report_mismatch("status", int'(result.status), int'(want.status));
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("[first_fit_coalescing_allocator] ERROR");
			$finish;
		end
	end

	task automatic send_request(mode_t m, int size, int addr);
		request_t req;
		result_t want;
		int i;
		if (gap_percent > 0 && $urandom_range(99) < gap_percent) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req.mode = m;
		req.request_size = ADDR_W'(size);
		req.block_address = ADDR_W'(addr);
		start <= 1'b1;
		request <= req;
		do @(posedge clk); while (busy);
		want = predict_heap(req);
		pending_results.push_back(want);
		if (want.status == ST_OK) begin
			if (m == MODE_ALLOC) begin
				live_blocks.push_back(int'(want.payload_address));
			end else begin
				for (i = 0; i < live_blocks.size(); i++)
					if (live_blocks[i] == addr) begin
						live_blocks.delete(i);
						break;
					end
			end
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic test_boundaries();
		send_request(MODE_ALLOC, 4095, 0);
		send_request(MODE_ALLOC, 4080, 0);
		send_request(MODE_FREE, 0, 0);
		send_request(MODE_FREE, 0, 15);
		send_request(MODE_FREE, 0, 4095);
		send_request(MODE_FREE, 0, 16);
		send_request(MODE_ALLOC, 4064, 0);
		send_request(MODE_ALLOC, 0, 0);
		send_request(MODE_FREE, 0, 16);
		send_request(MODE_FREE, 0, 16);
	endtask

	task automatic test_split_and_merge();
		send_request(MODE_ALLOC, 0, 0);
		send_request(MODE_ALLOC, 100, 0);
		send_request(MODE_ALLOC, 40, 0);
		send_request(MODE_ALLOC, 4095, 0);
		send_request(MODE_FREE, 0, 50);
		send_request(MODE_FREE, 0, 32);
		send_request(MODE_FREE, 0, 148);
		send_request(MODE_FREE, 0, 16);
		send_request(MODE_ALLOC, 3000, 0);
		send_request(MODE_ALLOC, 1050, 0);
		send_request(MODE_FREE, 0, 16);
		send_request(MODE_FREE, 0, 3032);
	endtask

	task automatic test_random(int count);
		int n, pick;
		for (n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 45)
				send_request(MODE_ALLOC, $urandom_range(0, 200), $urandom_range(0, 4095));
			else if (pick < 52)
				send_request(MODE_ALLOC, $urandom_range(0, 4095), $urandom_range(0, 4095));
			else if (pick < 88 && live_blocks.size() > 0)
				send_request(MODE_FREE, $urandom_range(0, 4095),
					live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
			else
				send_request(MODE_FREE, $urandom_range(0, 4095), $urandom_range(0, 4095));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		error_count = 0;
		gap_percent = 21;
		heap_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_boundaries();
		test_split_and_merge();
		test_random(400);
		wait_drained();
		gap_percent = 58;
		test_random(450);
		gap_percent = 0;
		test_random(430);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("[first_fit_coalescing_allocator] OK");
		else
			$display("[first_fit_coalescing_allocator] ERROR");
		$finish;
	end

endmodule
`default_nettype wire
